// ===== sv/kmst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types and constants of the spanning tree acceptance block: field
// widths, the packed forest entry, the forest port command and the sequencer
// states.
// ----------------------------------------------------------------------------
package kmst_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int COUNT_BITS  = NODE_BITS + 1;
    localparam int RANK_BITS   = 4;
    localparam int WEIGHT_BITS = 16;
    localparam int COST_BITS   = 26;

    localparam logic [RANK_BITS-1:0]  RANK_MAX     = '1;
    localparam logic [NODE_BITS-1:0]  NODE_MAX_IDX = NODE_BITS'(MAX_NODES - 1);
    localparam logic [COUNT_BITS-1:0] NODES_FULL   = COUNT_BITS'(MAX_NODES);

    localparam logic OP_START = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    typedef struct packed {
        logic [RANK_BITS-1:0] rank;
        logic [NODE_BITS-1:0] parent;
    } forest_entry_t;

    typedef struct packed {
        logic [NODE_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic [NODE_BITS-1:0] wr_addr;
        forest_entry_t        wr_data;
    } forest_cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_ISSUE,
        ST_FIND,
        ST_COMP_ISSUE,
        ST_COMP,
        ST_UNION_LO,
        ST_UNION_HI,
        ST_FINAL
    } mst_state_t;

endpackage
`default_nettype wire

// ===== sv/kruskal_union_find_mst_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kruskal_union_find_mst_top
// Spanning tree acceptance stage: a union-find forest with path compression
// and union by rank, fed with edges in ascending weight order.
// ----------------------------------------------------------------------------
// Usage: the s_ channel carries one item per beat, a start (opcode 0) that
// clears the forest or an edge (opcode 1). Every item gives exactly one beat
// on the m_ channel with the running cost, counts and flags. node_count is
// written through cfg_wr_en/cfg_wr_data; the user must write it only while
// the block is idle, as the block itself does not enforce this.
// Sequence: one sequencer walks the forest store, one entry read per cycle.
// For an edge it finds the root of the first endpoint and compresses that
// path, does the same for the second endpoint, then links the two roots
// when they differ, writing the raised rank too when the union raises one.
// A root walk is at most log2 of the node count, so 10 links, and a
// compression pass follows only a walk that is not empty. The result beat
// becomes valid in the same cycle as the block is ready again. A bad or
// late edge goes straight to its result. A start item sweeps all 1024
// forest entries; after reset the same sweep runs and s_ready stays low.
// Stall: a result waits in the output register; the block accepts the next
// item meanwhile and holds its own result back until the register is free.
// ----------------------------------------------------------------------------
module kruskal_union_find_mst_top
    import kmst_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_wr_en,
    input  wire logic [COUNT_BITS-1:0]  cfg_wr_data,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_opcode,
    input  wire logic [NODE_BITS-1:0]   s_first_node,
    input  wire logic [NODE_BITS-1:0]   s_second_node,
    input  wire logic signed [WEIGHT_BITS-1:0] s_weight,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_accepted,
    output logic signed [COST_BITS-1:0] m_tree_cost,
    output logic [NODE_BITS-1:0]        m_edges_taken,
    output logic [COUNT_BITS-1:0]       m_components,
    output logic                        m_complete,
    output logic                        m_bad_node
);

    mst_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0]  node_count_reg;
    logic                   op_reg,      op_next;
    logic [NODE_BITS-1:0]   a_reg,       a_next;
    logic [NODE_BITS-1:0]   b_reg,       b_next;
    logic [WEIGHT_BITS-1:0] weight_reg,  weight_next;
    logic                   side_reg,    side_next;
    logic [NODE_BITS-1:0]   cur_reg,     cur_next;
    logic [NODE_BITS-1:0]   root_a_reg,  root_a_next;
    logic [RANK_BITS-1:0]   rank_a_reg,  rank_a_next;
    logic [NODE_BITS-1:0]   root_b_reg,  root_b_next;
    logic [RANK_BITS-1:0]   rank_b_reg,  rank_b_next;

    logic [COST_BITS-1:0]   cost_reg,    cost_next;
    logic [NODE_BITS-1:0]   taken_reg,   taken_next;
    logic [COUNT_BITS-1:0]  sets_reg,    sets_next;
    logic                   done_reg,    done_next;
    logic                   acc_reg,     acc_next;
    logic                   bad_reg,     bad_next;
    logic                   reply_reg,   reply_next;

    logic                   m_valid_reg,      m_valid_next;
    logic                   m_accepted_reg,   m_accepted_next;
    logic [COST_BITS-1:0]   m_tree_cost_reg,  m_tree_cost_next;
    logic [NODE_BITS-1:0]   m_edges_reg,      m_edges_next;
    logic [COUNT_BITS-1:0]  m_components_reg, m_components_next;
    logic                   m_complete_reg,   m_complete_next;
    logic                   m_bad_node_reg,   m_bad_node_next;

    forest_cmd_t   fcmd;
    forest_entry_t rd_data;
    logic          clear_start;
    logic          forest_busy;

    kmst_forest u_forest (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (fcmd),
        .clear_start (clear_start),
        .rd_data     (rd_data),
        .busy        (forest_busy)
    );

    // Node count as the block uses it: zero acts as one, large values clamp.
    logic [COUNT_BITS-1:0] live_n;
    always_comb begin
        if (node_count_reg == '0) begin
            live_n = COUNT_BITS'(1);
        end else if (node_count_reg > NODES_FULL) begin
            live_n = NODES_FULL;
        end else begin
            live_n = node_count_reg;
        end
    end

    logic s_fire;
    logic in_bad;
    logic out_free;
    logic [NODE_BITS-1:0] start_node;
    logic [NODE_BITS-1:0] side_root;
    logic                 swap;
    logic [NODE_BITS-1:0] lo_node, hi_node;
    logic [RANK_BITS-1:0] lo_rank, hi_rank;
    logic                 raise_rank;
    logic                 tree_done;
    logic signed [COST_BITS:0] cost_sum;
    logic [COST_BITS-1:0]      cost_sat;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign in_bad     = ({1'b0, s_first_node} >= live_n) || ({1'b0, s_second_node} >= live_n);
    assign out_free   = !m_valid_reg || m_ready;
    assign start_node = side_reg ? b_reg : a_reg;
    assign side_root  = side_reg ? root_b_reg : root_a_reg;

    assign swap       = rank_a_reg > rank_b_reg;
    assign lo_node    = swap ? root_b_reg : root_a_reg;
    assign hi_node    = swap ? root_a_reg : root_b_reg;
    assign lo_rank    = swap ? rank_b_reg : rank_a_reg;
    assign hi_rank    = swap ? rank_a_reg : rank_b_reg;
    assign raise_rank = (lo_rank == hi_rank) && (hi_rank != RANK_MAX);

    assign tree_done  = done_reg || (op_reg == OP_EDGE
                                     && ({1'b0, taken_reg} + 1'b1) >= live_n);

    // Running cost with saturation at the signed limits of the cost field.
    assign cost_sum = $signed({cost_reg[COST_BITS-1], cost_reg})
                    + $signed({{(COST_BITS + 1 - WEIGHT_BITS){weight_reg[WEIGHT_BITS-1]}},
                               weight_reg});
    always_comb begin
        if (cost_sum[COST_BITS] != cost_sum[COST_BITS-1]) begin
            cost_sat = {cost_sum[COST_BITS], {(COST_BITS - 1){~cost_sum[COST_BITS]}}};
        end else begin
            cost_sat = cost_sum[COST_BITS-1:0];
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (!forest_busy) begin
                    state_next = reply_reg ? ST_FINAL : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_opcode == OP_START) begin
                        state_next = ST_CLEAR;
                    end else if (in_bad || done_reg) begin
                        state_next = ST_FINAL;
                    end else begin
                        state_next = ST_FIND_ISSUE;
                    end
                end
            end
            ST_FIND_ISSUE: state_next = ST_FIND;
            ST_FIND: begin
                if (rd_data.parent == cur_reg) begin
                    if (cur_reg != start_node) begin
                        state_next = ST_COMP_ISSUE;
                    end else begin
                        state_next = side_reg ? ST_UNION_LO : ST_FIND_ISSUE;
                    end
                end
            end
            ST_COMP_ISSUE: state_next = ST_COMP;
            ST_COMP: begin
                if (rd_data.parent == side_root) begin
                    state_next = side_reg ? ST_UNION_LO : ST_FIND_ISSUE;
                end
            end
            ST_UNION_LO: begin
                if (root_a_reg == root_b_reg || !raise_rank) begin
                    state_next = ST_FINAL;
                end else begin
                    state_next = ST_UNION_HI;
                end
            end
            ST_UNION_HI: state_next = ST_FINAL;
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath updates and forest commands.
    always_comb begin
        op_next           = op_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        weight_next       = weight_reg;
        side_next         = side_reg;
        cur_next          = cur_reg;
        root_a_next       = root_a_reg;
        rank_a_next       = rank_a_reg;
        root_b_next       = root_b_reg;
        rank_b_next       = rank_b_reg;
        cost_next         = cost_reg;
        taken_next        = taken_reg;
        sets_next         = sets_reg;
        done_next         = done_reg;
        acc_next          = acc_reg;
        bad_next          = bad_reg;
        reply_next        = reply_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_accepted_next   = m_accepted_reg;
        m_tree_cost_next  = m_tree_cost_reg;
        m_edges_next      = m_edges_reg;
        m_components_next = m_components_reg;
        m_complete_next   = m_complete_reg;
        m_bad_node_next   = m_bad_node_reg;
        fcmd.rd_addr      = cur_reg;
        fcmd.wr_en        = 1'b0;
        fcmd.wr_addr      = cur_reg;
        fcmd.wr_data      = rd_data;
        clear_start       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    op_next     = s_opcode;
                    a_next      = s_first_node;
                    b_next      = s_second_node;
                    weight_next = s_weight;
                    side_next   = 1'b0;
                    acc_next    = 1'b0;
                    bad_next    = (s_opcode == OP_EDGE) && in_bad;
                    if (s_opcode == OP_START) begin
                        clear_start = 1'b1;
                        reply_next  = 1'b1;
                        cost_next   = '0;
                        taken_next  = '0;
                        sets_next   = live_n;
                        done_next   = (live_n == COUNT_BITS'(1));
                    end
                end
            end
            ST_FIND_ISSUE: begin
                fcmd.rd_addr = start_node;
                cur_next     = start_node;
            end
            ST_FIND: begin
                if (rd_data.parent == cur_reg) begin
                    if (side_reg) begin
                        root_b_next = cur_reg;
                        rank_b_next = rd_data.rank;
                    end else begin
                        root_a_next = cur_reg;
                        rank_a_next = rd_data.rank;
                    end
                    // No path to compress when the endpoint is its own root.
                    if (cur_reg == start_node) begin
                        side_next = 1'b1;
                    end
                end else begin
                    fcmd.rd_addr = rd_data.parent;
                    cur_next     = rd_data.parent;
                end
            end
            ST_COMP_ISSUE: begin
                fcmd.rd_addr = start_node;
                cur_next     = start_node;
            end
            ST_COMP: begin
                fcmd.wr_en          = 1'b1;
                fcmd.wr_addr        = cur_reg;
                fcmd.wr_data.rank   = rd_data.rank;
                fcmd.wr_data.parent = side_root;
                fcmd.rd_addr        = rd_data.parent;
                cur_next            = rd_data.parent;
                if (rd_data.parent == side_root) begin
                    side_next = 1'b1;
                end
            end
            ST_UNION_LO: begin
                if (root_a_reg != root_b_reg) begin
                    fcmd.wr_en          = 1'b1;
                    fcmd.wr_addr        = lo_node;
                    fcmd.wr_data.rank   = lo_rank;
                    fcmd.wr_data.parent = hi_node;
                    cost_next           = cost_sat;
                    taken_next          = taken_reg + 1'b1;
                    acc_next            = 1'b1;
                    if (sets_reg > COUNT_BITS'(1)) begin
                        sets_next = sets_reg - 1'b1;
                    end
                end
            end
            ST_UNION_HI: begin
                fcmd.wr_en          = 1'b1;
                fcmd.wr_addr        = hi_node;
                fcmd.wr_data.rank   = hi_rank + 1'b1;
                fcmd.wr_data.parent = hi_node;
            end
            ST_FINAL: begin
                if (out_free) begin
                    done_next         = tree_done;
                    reply_next        = 1'b0;
                    m_valid_next      = 1'b1;
                    m_accepted_next   = acc_reg;
                    m_tree_cost_next  = cost_reg;
                    m_edges_next      = taken_reg;
                    m_components_next = sets_reg;
                    m_complete_next   = tree_done;
                    m_bad_node_next   = bad_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            node_count_reg <= NODES_FULL;
            cost_reg       <= '0;
            taken_reg      <= '0;
            sets_reg       <= NODES_FULL;
            done_reg       <= 1'b0;
            reply_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cost_reg    <= cost_next;
            taken_reg   <= taken_next;
            sets_reg    <= sets_next;
            done_reg    <= done_next;
            reply_reg   <= reply_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg           <= op_next;
        a_reg            <= a_next;
        b_reg            <= b_next;
        weight_reg       <= weight_next;
        side_reg         <= side_next;
        cur_reg          <= cur_next;
        root_a_reg       <= root_a_next;
        rank_a_reg       <= rank_a_next;
        root_b_reg       <= root_b_next;
        rank_b_reg       <= rank_b_next;
        acc_reg          <= acc_next;
        bad_reg          <= bad_next;
        m_accepted_reg   <= m_accepted_next;
        m_tree_cost_reg  <= m_tree_cost_next;
        m_edges_reg      <= m_edges_next;
        m_components_reg <= m_components_next;
        m_complete_reg   <= m_complete_next;
        m_bad_node_reg   <= m_bad_node_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_accepted    = m_accepted_reg;
    assign m_tree_cost   = m_tree_cost_reg;
    assign m_edges_taken = m_edges_reg;
    assign m_components  = m_components_reg;
    assign m_complete    = m_complete_reg;
    assign m_bad_node    = m_bad_node_reg;

    // No item may enter while the clearing sweep owns the forest.
    assert property (@(posedge aclk) disable iff (!aresetn)
        forest_busy |-> !s_ready)
        else $error("item accepted during forest clearing sweep");

    // An edge with a bad endpoint is never taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_accepted && m_bad_node))
        else $error("result both accepted and flagged bad");

    // A taken edge always leaves a nonzero count of taken edges.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accepted) |-> (m_edges_taken != '0))
        else $error("taken edge count wrapped");

    // The rank raise only follows the union write.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UNION_HI) |-> $past(state_reg == ST_UNION_LO))
        else $error("rank raise without a preceding union");

endmodule
`default_nettype wire

// ===== sv/kmst_forest.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmst_forest
// Disjoint-set forest store: one entry per node holding its parent and rank,
// one write and one registered read per cycle, and a clearing sweep that
// makes every node its own root with rank zero.
// ----------------------------------------------------------------------------
module kmst_forest
    import kmst_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire forest_cmd_t   cmd,
    input  wire logic          clear_start,
    output forest_entry_t      rd_data,
    output logic               busy
);

    forest_entry_t mem [MAX_NODES];
    forest_entry_t rd_data_reg;

    logic                 busy_reg,  busy_next;
    logic [NODE_BITS-1:0] sweep_reg, sweep_next;

    logic                 wr_en;
    logic [NODE_BITS-1:0] wr_addr;
    forest_entry_t        wr_data;

    always_comb begin
        busy_next  = busy_reg;
        sweep_next = sweep_reg;
        if (busy_reg) begin
            sweep_next = sweep_reg + 1'b1;
            if (sweep_reg == NODE_MAX_IDX) begin
                busy_next = 1'b0;
            end
        end else if (clear_start) begin
            busy_next  = 1'b1;
            sweep_next = '0;
        end
    end

    // The sweep owns the write port while it runs.
    always_comb begin
        if (busy_reg) begin
            wr_en          = 1'b1;
            wr_addr        = sweep_reg;
            wr_data.rank   = '0;
            wr_data.parent = sweep_reg;
        end else begin
            wr_en   = cmd.wr_en;
            wr_addr = cmd.wr_addr;
            wr_data = cmd.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[cmd.rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule
`default_nettype wire
